[rtl/stkit_pkg.sv]
package stkit_pkg;

   // Table size and preload constants
   localparam int DEFAULT_DEPTH = 8;
   localparam int SCORE_STEP    = 1000;
   localparam logic [7:0] TAG_BASE_CHAR = 8'h41;

   localparam int SCORE_W = 32;
   localparam int TAG_W   = 24;
   localparam int INDEX_W = 8;
   localparam int PLACE_W = 3;

   // Request codes
   localparam logic [1:0] REQ_CHECK  = 2'd0;
   localparam logic [1:0] REQ_INSERT = 2'd1;
   localparam logic [1:0] REQ_READ   = 2'd2;

   typedef struct packed {
      logic [1:0]         req_type;
      logic [SCORE_W-1:0] score;
      logic [TAG_W-1:0]   tag;
      logic [INDEX_W-1:0] index;
   } stkit_req_type;

   typedef struct packed {
      logic               qualifies;
      logic [PLACE_W-1:0] placed_at;
      logic               read_valid;
      logic [SCORE_W-1:0] read_score;
      logic [TAG_W-1:0]   read_tag;
   } stkit_rsp_type;

   // Broadcast to every cell: qualified insert and the offered entry
   typedef struct packed {
      logic               ins_en;
      logic [SCORE_W-1:0] score;
      logic [TAG_W-1:0]   tag;
   } stkit_cmd_type;

   // Handed from a cell to its lower neighbor
   typedef struct packed {
      logic [SCORE_W-1:0] score;
      logic [TAG_W-1:0]   tag;
      logic               le;     // stored score <= offered score
   } stkit_link_type;

endpackage

[rtl/stkit_cell.sv]
module stkit_cell #(
   parameter logic [31:0] INIT_SCORE = 32'd1000,
   parameter logic [23:0] INIT_TAG   = 24'h414141,
   parameter bit          IS_BOTTOM  = 1'b0
) (
   input  logic                     clock,
   input  logic                     reset,
   input  stkit_pkg::stkit_cmd_type  cmd,
   input  stkit_pkg::stkit_link_type from_up,
   output stkit_pkg::stkit_link_type to_down,
   output logic                     take_new
);
   import stkit_pkg::*;

   logic [SCORE_W-1:0] score_ff, score_in;
   logic [TAG_W-1:0]   tag_ff, tag_in;
   logic               le_own;
   logic               shift;

   assign le_own   = (score_ff <= cmd.score);
   // upper neighbor also at or below the new score: move its entry down
   assign shift    = cmd.ins_en && from_up.le;
   // bottom cell only sees qualified inserts, so it always has room
   assign take_new = cmd.ins_en && !from_up.le && (IS_BOTTOM || le_own);

   always_comb begin
      score_in = score_ff;
      tag_in   = tag_ff;
      if (shift) begin
         score_in = from_up.score;
         tag_in   = from_up.tag;
      end else if (take_new) begin
         score_in = cmd.score;
         tag_in   = cmd.tag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         score_ff <= INIT_SCORE;
         tag_ff   <= INIT_TAG;
      end else begin
         score_ff <= score_in;
         tag_ff   <= tag_in;
      end
   end

   assign to_down.score = score_ff;
   assign to_down.tag   = tag_ff;
   assign to_down.le    = le_own;

endmodule

[rtl/sorted_top_k_insert_table_top.sv]
// Sorted top-k table: TABLE_DEPTH entries of 32-bit score plus 3-char tag, kept
// ascending (slot 0 lowest) in a row of cells. Reset preloads slot i with score
// (i+1)*1000 and tag 'A'+i in all three bytes. A check item reports whether its
// score beats slot 0; an insert item also lands the score above any equal ones,
// the old slot 0 drops out. A read item returns slot `index` with a valid flag.
// One item per clock while no result is stalled: every cell compares against
// the offered score and moves in the same cycle, and the result goes into an
// output register that still lets the next item in while it is being taken.
module sorted_top_k_insert_table_top #(
   parameter int TABLE_DEPTH = stkit_pkg::DEFAULT_DEPTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  stkit_pkg::stkit_req_type req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output stkit_pkg::stkit_rsp_type rsp_data
);
   import stkit_pkg::*;

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam logic [INDEX_W:0] DEPTH_LIM = (INDEX_W+1)'(TABLE_DEPTH);

   logic           accept;
   logic           qualify;
   stkit_cmd_type  cmd;
   stkit_link_type links [0:TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] take_vec;
   logic [PLACE_W-1:0]     place;
   logic           in_range;

   logic           rsp_valid_ff, rsp_valid_in;
   stkit_rsp_type  rsp_data_ff, rsp_data_in;

   // output register frees up as soon as its item is taken
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // strict beat of the lowest entry
   assign qualify = (req_data.score > links[0].score);

   assign cmd.ins_en = accept && (req_data.req_type == REQ_INSERT) && qualify;
   assign cmd.score  = req_data.score;
   assign cmd.tag    = req_data.tag;

   // nothing above the top cell
   assign links[TABLE_DEPTH].score = '0;
   assign links[TABLE_DEPTH].tag   = '0;
   assign links[TABLE_DEPTH].le    = 1'b0;

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      stkit_cell #(
         .INIT_SCORE (SCORE_W'((i + 1) * SCORE_STEP)),
         .INIT_TAG   ({3{TAG_BASE_CHAR + 8'(i)}}),
         .IS_BOTTOM  (i == 0)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .cmd      (cmd),
         .from_up  (links[i+1]),
         .to_down  (links[i]),
         .take_new (take_vec[i])
      );
   end

   // landing slot, low bits only; at most one cell takes the new entry
   always_comb begin
      place = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (take_vec[i]) begin
            place = place | PLACE_W'(i);
         end
      end
   end

   assign in_range = ({1'b0, req_data.index} < DEPTH_LIM);

   always_comb begin
      rsp_data_in = '0;
      case (req_data.req_type)
         REQ_CHECK: begin
            rsp_data_in.qualifies = qualify;
         end
         REQ_INSERT: begin
            rsp_data_in.qualifies = qualify;
            rsp_data_in.placed_at = qualify ? place : '0;
         end
         REQ_READ: begin
            if (in_range) begin
               rsp_data_in.read_valid = 1'b1;
               rsp_data_in.read_score = links[req_data.index[IDX_W-1:0]].score;
               rsp_data_in.read_tag   = links[req_data.index[IDX_W-1:0]].tag;
            end
         end
         default: begin
            rsp_data_in = '0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---- checks ----
   a_one_landing: assert property (@(posedge clock) disable iff (reset)
      $onehot0(take_vec))
      else $error("more than one cell took the new entry");

   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted item produced no result");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !req_ready)
      else $error("new item taken while result stalled");

   a_place_needs_q: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_data_ff.placed_at != '0)) |-> rsp_data_ff.qualifies)
      else $error("placement reported for a score that did not qualify");

   a_insert_lands: assert property (@(posedge clock) disable iff (reset)
      cmd.ins_en |-> (take_vec != '0))
      else $error("qualified insert found no slot");

endmodule
